// File: rtl/core/srp5_pkg.sv
package srp5_pkg;

   // default fraction bits of the angle word and depth of the work queue
   localparam int ANGLE_FRAC_BITS_DEF = 16;
   localparam int QUEUE_DEPTH_DEF     = 4;

   // number of stages in the evaluation pipe, output register included
   localparam int BACK_STAGES = 11;

   // 1/pi as unsigned Q0.32, pi as Q4.60
   localparam logic [31:0] INVPI_Q32 = 32'h517C_C1B7;
   localparam logic [63:0] PI_Q60    = 64'h3243_F6A8_885A_308D;

   // quintic coefficients, Q2.30
   localparam logic [22:0]        POLY_A = 23'd7894653;
   localparam logic signed [31:0] POLY_B = -32'sd177477835;
   localparam logic signed [31:0] POLY_C = 32'sd1073411097;

   // half an LSB of Q2.30 when a Q4.60 product is brought back to Q2.30
   localparam logic signed [63:0] ROUND_Q30 = 64'sd536870912;

   // coefficient plus rounding offset, both at Q4.60, folded into one addend
   localparam logic signed [63:0] T_BIAS = (64'(POLY_B) <<< 30) + ROUND_Q30;
   localparam logic signed [63:0] U_BIAS = (64'(POLY_C) <<< 30) + ROUND_Q30;

endpackage

// File: rtl/core/sine_range_reduce_poly5.sv
// Fast fixed-point sine: range reduction by pi and an odd quintic.
//
// Input channel req_: one angle word per handshake, signed, radians, with
// ANGLE_FRAC_BITS fraction bits. Result channel rsp_: one sine word per
// angle, signed Q2.30, in the order the angles were taken.
//
// The front rounds angle/pi to an integer k in three stages and pushes the
// word into a QUEUE_DEPTH deep queue. The back pipe of eleven stages
// subtracts k*pi and evaluates the polynomial. While rsp_ready stays high
// one angle is taken and one result given every cycle.
//
// Reset clears all valid bits and the queue; no warm-up is needed. When the
// receiver holds rsp_ready low the back pipe holds, the queue fills, then
// the front holds and req_ready drops; nothing is lost or repeated.
module sine_range_reduce_poly5 #(
   parameter int ANGLE_FRAC_BITS = srp5_pkg::ANGLE_FRAC_BITS_DEF,
   parameter int QUEUE_DEPTH     = srp5_pkg::QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_angle,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_sine
);

   localparam int IW = 32 - ANGLE_FRAC_BITS + 33;

   logic          push_valid, push_ready;
   logic [IW-1:0] push_data;
   logic          pop_valid, pop_ready;
   logic [IW-1:0] pop_data;

   // classify: sign, magnitude, nearest multiple of pi
   srp5_front #(
      .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_angle  (req_angle),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // decouple front and back
   srp5_queue #(
      .DATA_W (IW),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // reduce and evaluate
   srp5_back #(
      .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_sine  (rsp_sine)
   );

endmodule

// File: rtl/core/srp5_front.sv
module srp5_front #(
   parameter int ANGLE_FRAC_BITS = srp5_pkg::ANGLE_FRAC_BITS_DEF,
   localparam int QW = 32 - ANGLE_FRAC_BITS,
   localparam int IW = QW + 33
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_angle,
   output logic               push_valid,
   input  logic               push_ready,
   output logic [IW-1:0]      push_data
);

   localparam int S = ANGLE_FRAC_BITS + 32;

   logic [2:0]    f_v_ff, f_v_in;
   logic          adv;

   logic          f1_neg_ff, f1_neg_in;
   logic [31:0]   f1_mag_ff, f1_mag_in;
   logic          f2_neg_ff;
   logic [31:0]   f2_mag_ff;
   logic [63:0]   f2_prod_ff, f2_prod_in;
   logic          f3_neg_ff;
   logic [31:0]   f3_mag_ff;
   logic [QW-1:0] f3_q_ff, f3_q_in;
   logic          round_up;

   // advance the whole front when its last stage is empty or drains
   assign adv       = !f_v_ff[2] || push_ready;
   assign req_ready = adv;
   assign f_v_in    = {f_v_ff[1:0], req_valid};

   // split off the sign and take the magnitude
   assign f1_neg_in = req_angle[31];
   assign f1_mag_in = req_angle[31] ? (~req_angle + 32'd1) : req_angle;

   // scale the magnitude by 1/pi
   assign f2_prod_in = 64'(f1_mag_ff) * 64'(srp5_pkg::INVPI_Q32);

   // round to nearest integer, ties to even
   assign round_up = f2_prod_ff[S-1] && ((|f2_prod_ff[S-2:0]) || f2_prod_ff[S]);
   assign f3_q_in  = f2_prod_ff[63:S] + QW'(round_up);

   always_ff @(posedge clock) begin
      if (reset) begin
         f_v_ff <= '0;
      end else if (adv) begin
         f_v_ff <= f_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_neg_ff  <= f1_neg_in;
         f1_mag_ff  <= f1_mag_in;
         f2_neg_ff  <= f1_neg_ff;
         f2_mag_ff  <= f1_mag_ff;
         f2_prod_ff <= f2_prod_in;
         f3_neg_ff  <= f2_neg_ff;
         f3_mag_ff  <= f2_mag_ff;
         f3_q_ff    <= f3_q_in;
      end
   end

   // hand the classified word to the queue
   assign push_valid = f_v_ff[2];
   assign push_data  = {f3_neg_ff, f3_mag_ff, f3_q_ff};

endmodule

// File: rtl/core/srp5_queue.sv
module srp5_queue #(
   parameter int DATA_W = 49,
   parameter int DEPTH  = srp5_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [DATA_W-1:0] push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [DATA_W-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, pop;

   // full and empty come from the registered count only
   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = mem_ff[rd_ptr_ff];

   assign push = push_valid && push_ready;
   assign pop  = pop_valid && pop_ready;

   // wrap the pointers at the depth
   assign wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
      end
   end

   // store the pushed word
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == CNT_W'($past(count_ff) + 1'b1))
      else $error("queue count missed a push");

   a_count_down: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == CNT_W'($past(count_ff) - 1'b1))
      else $error("queue count missed a pop");
`endif

endmodule

// File: rtl/core/srp5_back.sv
module srp5_back #(
   parameter int ANGLE_FRAC_BITS = srp5_pkg::ANGLE_FRAC_BITS_DEF,
   localparam int QW = 32 - ANGLE_FRAC_BITS,
   localparam int IW = QW + 33
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  logic [IW-1:0]      pop_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_sine
);

   localparam int NS = srp5_pkg::BACK_STAGES;
   localparam int F  = ANGLE_FRAC_BITS;
   localparam int PS = 30 - F;
   localparam int DW = F + 33;
   localparam int PW = F + 1;

   // pi at Q(F+30), split into a low word and the bits above it that matter
   localparam logic [63:0]    PI_W   = (srp5_pkg::PI_Q60 + (64'd1 << (PS - 1))) >> PS;
   localparam logic [31:0]    PI_LO  = PI_W[31:0];
   localparam logic [PW-1:0]  PI_HI  = PI_W[DW-1:32];
   localparam logic [DW-1:0]  HALF_F = DW'(64'd1 << (F - 1));

   logic [NS-1:0] v_ff, v_in;
   logic          adv;

   logic          in_neg;
   logic [31:0]   in_mag;
   logic [QW-1:0] in_q;

   logic [QW+31:0] pl_full;
   logic [QW+PW-1:0] ph_full;

   // stage 1: k times pi, low and high parts
   logic          b1_neg_ff, b1_odd_ff;
   logic [31:0]   b1_mag_ff;
   logic [DW-1:0] b1_pl_ff, b1_pl_in;
   logic [PW-1:0] b1_ph_ff, b1_ph_in;
   // stage 2: magnitude difference
   logic          b2_neg_ff, b2_odd_ff;
   logic [DW-1:0] b2_d_ff, b2_d_in;
   // stage 3: signed reduced angle in Q2.30
   logic                 b3_odd_ff;
   logic [DW-1:0]        diff, rsum;
   logic signed [31:0]   b3_r_ff, b3_r_in;
   // stage 4: r squared
   logic                 b4_odd_ff;
   logic signed [31:0]   b4_r_ff;
   logic signed [63:0]   b4_rr_ff, b4_rr_in;
   // stage 5: x2 in Q2.30
   logic                 b5_odd_ff;
   logic signed [31:0]   b5_r_ff;
   logic [63:0]          x2sum;
   logic [31:0]          b5_x2_ff, b5_x2_in;
   // stage 6: A times x2
   logic                 b6_odd_ff;
   logic signed [31:0]   b6_r_ff;
   logic [31:0]          b6_x2_ff;
   logic [55:0]          b6_ax_ff, b6_ax_in;
   // stage 7: t = B + A*x2
   logic                 b7_odd_ff;
   logic signed [31:0]   b7_r_ff;
   logic [31:0]          b7_x2_ff;
   logic signed [63:0]   tsum;
   logic signed [31:0]   b7_t_ff, b7_t_in;
   // stage 8: x2 times t
   logic                 b8_odd_ff;
   logic signed [31:0]   b8_r_ff;
   logic signed [32:0]   x2s;
   logic signed [63:0]   b8_xt_ff, b8_xt_in;
   // stage 9: u = C + x2*t
   logic                 b9_odd_ff;
   logic signed [31:0]   b9_r_ff;
   logic signed [63:0]   usum;
   logic signed [31:0]   b9_u_ff, b9_u_in;
   // stage 10: r times u
   logic                 b10_odd_ff;
   logic signed [63:0]   b10_ry_ff, b10_ry_in;
   // stage 11: round, fold sign, saturate
   logic signed [63:0]   ysum;
   logic signed [33:0]   y;
   logic signed [34:0]   ys;
   logic signed [31:0]   sine_ff, sine_in;

   // advance the pipe when the output register is empty or taken
   assign adv       = !v_ff[NS-1] || rsp_ready;
   assign pop_ready = adv;
   assign v_in      = {v_ff[NS-2:0], pop_valid};

   assign {in_neg, in_mag, in_q} = pop_data;

   // stage 1
   assign pl_full  = (QW + 32)'(in_q) * (QW + 32)'(PI_LO);
   assign ph_full  = (QW + PW)'(in_q) * (QW + PW)'(PI_HI);
   assign b1_pl_in = DW'(pl_full);
   assign b1_ph_in = ph_full[PW-1:0];

   // stage 2: only the low DW bits count, the true difference is small
   assign b2_d_in = DW'({b1_mag_ff, 30'd0}) - b1_pl_ff - {b1_ph_ff, 32'd0};

   // stage 3: restore the sign, round away the extra fraction bits
   assign diff    = b2_neg_ff ? (~b2_d_ff + 1'b1) : b2_d_ff;
   assign rsum    = diff + HALF_F;
   assign b3_r_in = $signed(rsum[F+31:F]);

   // stage 4
   assign b4_rr_in = 64'(b3_r_ff) * 64'(b3_r_ff);

   // stage 5: square is never negative
   assign x2sum    = $unsigned(b4_rr_ff) + $unsigned(srp5_pkg::ROUND_Q30);
   assign b5_x2_in = x2sum[61:30];

   // stage 6
   assign b6_ax_in = 56'(b5_x2_ff) * 56'(srp5_pkg::POLY_A);

   // stage 7
   assign tsum    = $signed({8'd0, b6_ax_ff}) + srp5_pkg::T_BIAS;
   assign b7_t_in = tsum[61:30];

   // stage 8
   assign x2s      = $signed({1'b0, b7_x2_ff});
   assign b8_xt_in = 64'(x2s) * 64'(b7_t_ff);

   // stage 9
   assign usum    = b8_xt_ff + srp5_pkg::U_BIAS;
   assign b9_u_in = usum[61:30];

   // stage 10
   assign b10_ry_in = 64'(b9_r_ff) * 64'(b9_u_ff);

   // stage 11: negate for odd k, clamp to the word range
   assign ysum = b10_ry_ff + srp5_pkg::ROUND_Q30;
   assign y    = ysum[63:30];
   assign ys   = b10_odd_ff ? -35'(y) : 35'(y);

   always_comb begin
      priority if (ys > 35'sd2147483647) begin
         sine_in = 32'sh7FFF_FFFF;
      end else if (ys < -35'sd2147483648) begin
         sine_in = 32'sh8000_0000;
      end else begin
         sine_in = ys[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b1_neg_ff  <= in_neg;
         b1_odd_ff  <= in_q[0];
         b1_mag_ff  <= in_mag;
         b1_pl_ff   <= b1_pl_in;
         b1_ph_ff   <= b1_ph_in;
         b2_neg_ff  <= b1_neg_ff;
         b2_odd_ff  <= b1_odd_ff;
         b2_d_ff    <= b2_d_in;
         b3_odd_ff  <= b2_odd_ff;
         b3_r_ff    <= b3_r_in;
         b4_odd_ff  <= b3_odd_ff;
         b4_r_ff    <= b3_r_ff;
         b4_rr_ff   <= b4_rr_in;
         b5_odd_ff  <= b4_odd_ff;
         b5_r_ff    <= b4_r_ff;
         b5_x2_ff   <= b5_x2_in;
         b6_odd_ff  <= b5_odd_ff;
         b6_r_ff    <= b5_r_ff;
         b6_x2_ff   <= b5_x2_ff;
         b6_ax_ff   <= b6_ax_in;
         b7_odd_ff  <= b6_odd_ff;
         b7_r_ff    <= b6_r_ff;
         b7_x2_ff   <= b6_x2_ff;
         b7_t_ff    <= b7_t_in;
         b8_odd_ff  <= b7_odd_ff;
         b8_r_ff    <= b7_r_ff;
         b8_xt_ff   <= b8_xt_in;
         b9_odd_ff  <= b8_odd_ff;
         b9_r_ff    <= b8_r_ff;
         b9_u_ff    <= b9_u_in;
         b10_odd_ff <= b9_odd_ff;
         b10_ry_ff  <= b10_ry_in;
         sine_ff    <= sine_in;
      end
   end

   assign rsp_valid = v_ff[NS-1];
   assign rsp_sine  = sine_ff;

`ifndef SYNTHESIS
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(v_ff))
      else $error("pipe moved while the output was stalled");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(v_ff[NS-2]))
      else $error("result appeared without a word in the stage before");
`endif

endmodule

// File: tb/sine_range_reduce_poly5_test.sv
`timescale 1ns / 100ps

module sine_range_reduce_poly5_test;

   localparam int  FRAC           = srp5_pkg::ANGLE_FRAC_BITS_DEF;
   localparam int  RANDOM_ANGLES  = 830;
   localparam int  TAIL_CYCLES    = 40;
   localparam int  CYCLE_LIMIT    = 200000;
   localparam real PI_R           = 3.14159265358979323846;

   // fixed-point constants of the sine approximation
   localparam longint unsigned RECIP_PI_Q32 = 64'h0000_0000_517C_C1B7;
   localparam longint          PI_Q4_60     = 64'h3243_F6A8_885A_308D;
   localparam longint          COEF_A       = 64'sd7894653;
   localparam longint          COEF_B       = -64'sd177477835;
   localparam longint          COEF_C       = 64'sd1073411097;

   // expected sine words, oldest first, and the checks against them
   class sine_scoreboard;
      logic signed [31:0] expected_sines[$];
      int angles_seen;
      int sines_checked;
      int errors;

      // floor((v + half) / 2^s): round half toward +infinity
      function longint round_up_shift(longint v, int s);
         return (v + (longint'(1) <<< (s - 1))) >>> s;
      endfunction

      function logic signed [31:0] predict_sine(logic signed [31:0] angle);
         longint          a, k, pi_w, diff, r, x2, t, u, y;
         longint unsigned mag, prod, q, rem, half;
         bit              neg;
         neg  = angle[31];
         a    = longint'(angle);
         mag  = neg ? longint'(-a) : longint'(a);
         // nearest multiple of pi, ties to even
         prod = mag * RECIP_PI_Q32;
         q    = prod >> (FRAC + 32);
         rem  = prod & ((64'd1 << (FRAC + 32)) - 64'd1);
         half = 64'd1 << (FRAC + 31);
         if (rem > half || (rem == half && q[0]))
            q++;
         k = neg ? -longint'(q) : longint'(q);
         // reduced angle at Q(FRAC+30), then Q2.30
         pi_w = (PI_Q4_60 + (longint'(1) <<< (29 - FRAC))) >>> (30 - FRAC);
         diff = a * (longint'(1) <<< 30) - k * pi_w;
         r    = round_up_shift(diff, FRAC);
         // odd quintic
         x2 = round_up_shift(r * r, 30);
         t  = COEF_B + round_up_shift(COEF_A * x2, 30);
         u  = COEF_C + round_up_shift(x2 * t, 30);
         y  = round_up_shift(r * u, 30);
         if (q[0])
            y = -y;
         if (y > 64'sd2147483647)
            y = 64'sd2147483647;
         if (y < -64'sd2147483648)
            y = -64'sd2147483648;
         return y[31:0];
      endfunction

      function void note_angle(logic signed [31:0] angle);
         expected_sines.push_back(predict_sine(angle));
         angles_seen++;
      endfunction

      function void check_sine(logic signed [31:0] sine);
         logic signed [31:0] want;
         if (expected_sines.size() == 0) begin
            $error("sine word %0d arrived with no angle waiting", sine);
            errors++;
            return;
         end
         want = expected_sines.pop_front();
         sines_checked++;
         if (sine !== want) begin
            $error("sine mismatch: expected %0d, actual %0d", want, sine);
            errors++;
         end
      endfunction

      function int pending();
         return expected_sines.size();
      endfunction
   endclass

   logic               clock       = 1'b0;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   logic               req_ready;
   logic signed [31:0] req_angle   = '0;
   logic               rsp_valid;
   logic               rsp_ready   = 1'b0;
   logic signed [31:0] rsp_sine;

   int send_idle_pct = 9;
   int recv_idle_pct = 56;
   int cycle_count   = 0;
   int directed_count = 0;

   sine_scoreboard scoreboard = new();

   sine_range_reduce_poly5 #(
      .ANGLE_FRAC_BITS(FRAC)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_angle (req_angle),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_sine  (rsp_sine)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // stall the receiver at random
   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // note accepted angles and check accepted sine words
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            scoreboard.note_angle(req_angle);
         if (rsp_valid && rsp_ready)
            scoreboard.check_sine(rsp_sine);
      end
   end

   // stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // offer one angle word, with random idle cycles first; hold until taken
   task automatic send_angle(input logic signed [31:0] angle);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_angle <= angle;
      do
         @(posedge clock);
      while (!req_ready);
   endtask

   // drop valid and hold until every expected sine word has come back
   task automatic wait_for_sines();
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (scoreboard.pending() != 0);
   endtask

   // mix of full-range, small, tiny and near multiples of pi/2
   function automatic logic signed [31:0] random_angle();
      int  lim;
      int  n;
      real base;
      case ($urandom_range(9))
         0, 1, 2: return $urandom;
         3, 4, 5: return int'($urandom_range(0, 1 << 21)) - (1 << 20);
         6, 7, 8: begin
            lim  = int'(2.0 ** 31 / (PI_R / 2.0 * 2.0 ** FRAC)) - 2;
            n    = int'($urandom_range(0, 2 * lim)) - lim;
            base = n * (PI_R / 2.0) * 2.0 ** FRAC;
            return int'(base) + int'($urandom_range(0, 128)) - 64;
         end
         default: return int'($urandom_range(0, 510)) - 255;
      endcase
   endfunction

   initial begin : stimulus
      logic signed [31:0] directed_angles[$];
      int                 tie_k[$];
      int                 tie_word;
      directed_angles = '{32'sd0, 32'sd1, -32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000,
                          32'sh0001_0000, -32'sh0001_0000, 32'sh7FFF_0000,
                          32'sh8001_0000, 32'sh5555_5555, 32'shAAAA_AAAA};
      tie_k = '{0, 1, 2, -3, 6000, -6001};
      // pi, pi/2 and their negatives
      directed_angles.push_back(int'(PI_R * 2.0 ** FRAC));
      directed_angles.push_back(-int'(PI_R * 2.0 ** FRAC));
      directed_angles.push_back(int'(PI_R / 2.0 * 2.0 ** FRAC));
      directed_angles.push_back(-int'(PI_R / 2.0 * 2.0 ** FRAC));
      // angles right at a half multiple of pi, where k is closest to a tie
      foreach (tie_k[i]) begin
         tie_word = $rtoi((tie_k[i] + 0.5) * PI_R * 2.0 ** FRAC);
         directed_angles.push_back(tie_word);
         if (i == 1) begin
            directed_angles.push_back(tie_word + 1);
            directed_angles.push_back(tie_word - 1);
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_angles[i])
         send_angle(directed_angles[i]);
      directed_count = directed_angles.size();

      // three pacing phases: receiver-heavy stalls, sender-heavy gaps, none
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 9;
               recv_idle_pct = 56;
            end
            1: begin
               send_idle_pct = 56;
               recv_idle_pct = 9;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int i = 0; i < RANDOM_ANGLES / 3; i++) begin
            if (phase == 0 && i == RANDOM_ANGLES / 6)
               wait_for_sines();
            send_angle(random_angle());
         end
         wait_for_sines();
      end

      // catch any stray word after the last one
      repeat (TAIL_CYCLES) @(posedge clock);
      if (scoreboard.pending() != 0) begin
         $error("%0d sine words never arrived", scoreboard.pending());
         scoreboard.errors++;
      end

      $display("Run covered %0d angles (%0d directed, rest random over three pacing phases),",
               scoreboard.angles_seen, directed_count);
      $display("with %0d sine words compared and %0d failures found.",
               scoreboard.sines_checked, scoreboard.errors);
      if (scoreboard.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
